// File: design/atp_pkg.sv
// ----------------------------------------------------------------------------
// atp_pkg
// Shared types, constants and a helper function of the angle tracking PLL.
// ----------------------------------------------------------------------------
package atp_pkg;

    // Width of the angle accumulator and resolution of the sine lookup.
    localparam int ANGLE_BITS      = 16;
    localparam int SINE_TABLE_BITS = 10;
    localparam int TABLE_SHIFT     = 16 - SINE_TABLE_BITS;

    // Clears the phase bits below the sine table resolution.
    localparam logic [15:0] PHASE_MASK = 16'(16'hFFFF << TABLE_SHIFT);
    localparam logic [15:0] QUARTER_TURN = 16'h4000;
    localparam logic [16:0] Z_FULL = 17'd32768;

    // Polynomial coefficients of the quarter-wave sine, Q15.
    localparam logic [15:0] COEF_A = 16'd51437;
    localparam logic [15:0] COEF_B = 16'd20954;
    localparam logic [24:0] COEF_C = 25'd2285;

    // Configuration port.
    localparam int GAIN_BITS      = 24;
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PROP_GAIN  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INTEG_GAIN = 1'b1;
    localparam logic [GAIN_BITS-1:0] PROP_GAIN_RESET  = 24'd20861;
    localparam logic [GAIN_BITS-1:0] INTEG_GAIN_RESET = 24'd2086;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POLY1,
        ST_POLY2,
        ST_POLY3,
        ST_POLY4,
        ST_MIX,
        ST_ERR,
        ST_INTEG,
        ST_GAIN,
        ST_FREQ
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_POLY1,
        OP_POLY2,
        OP_POLY3,
        OP_POLY4,
        OP_MIX,
        OP_ERR,
        OP_INTEG,
        OP_GAIN,
        OP_FREQ
    } op_t;

    typedef struct packed {
        logic load;
        op_t  op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // Angle accumulator scaled to a 16-bit fraction of a turn.
    function automatic logic [15:0] turn_phase(input logic [ANGLE_BITS-1:0] ang);
        logic [ANGLE_BITS+15:0] wide;
        wide = {ang, 16'h0000};
        return 16'(wide >> ANGLE_BITS);
    endfunction

endpackage

// File: design/atp_ctrl.sv
// ----------------------------------------------------------------------------
// atp_ctrl
// Sequencer that steps the datapath through one loop update per item.
// ----------------------------------------------------------------------------
module atp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  atp_pkg::dp_status_t   status,
    output atp_pkg::ctrl_cmd_t    cmd
);

    atp_pkg::state_t state_reg;
    atp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= atp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            atp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = atp_pkg::ST_POLY1;
                end
            end
            atp_pkg::ST_POLY1: state_next = atp_pkg::ST_POLY2;
            atp_pkg::ST_POLY2: state_next = atp_pkg::ST_POLY3;
            atp_pkg::ST_POLY3: state_next = atp_pkg::ST_POLY4;
            atp_pkg::ST_POLY4: state_next = atp_pkg::ST_MIX;
            atp_pkg::ST_MIX:   state_next = atp_pkg::ST_ERR;
            atp_pkg::ST_ERR:   state_next = atp_pkg::ST_INTEG;
            atp_pkg::ST_INTEG: state_next = atp_pkg::ST_GAIN;
            atp_pkg::ST_GAIN:  state_next = atp_pkg::ST_FREQ;
            atp_pkg::ST_FREQ:
            begin
                // The result register must be free before the state commits.
                if (status.out_free)
                begin
                    state_next = atp_pkg::ST_IDLE;
                end
            end
            default: state_next = atp_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        cmd.load = 1'b0;
        cmd.op   = atp_pkg::OP_NONE;
        case (state_reg)
            atp_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            atp_pkg::ST_POLY1: cmd.op = atp_pkg::OP_POLY1;
            atp_pkg::ST_POLY2: cmd.op = atp_pkg::OP_POLY2;
            atp_pkg::ST_POLY3: cmd.op = atp_pkg::OP_POLY3;
            atp_pkg::ST_POLY4: cmd.op = atp_pkg::OP_POLY4;
            atp_pkg::ST_MIX:   cmd.op = atp_pkg::OP_MIX;
            atp_pkg::ST_ERR:   cmd.op = atp_pkg::OP_ERR;
            atp_pkg::ST_INTEG: cmd.op = atp_pkg::OP_INTEG;
            atp_pkg::ST_GAIN:  cmd.op = atp_pkg::OP_GAIN;
            atp_pkg::ST_FREQ:
            begin
                if (status.out_free)
                begin
                    cmd.op = atp_pkg::OP_FREQ;
                end
            end
            default: cmd.op = atp_pkg::OP_NONE;
        endcase
    end

endmodule

// File: design/atp_datapath.sv
// ----------------------------------------------------------------------------
// atp_datapath
// Two multiplier lanes, loop state, gain registers and the result register.
// ----------------------------------------------------------------------------
module atp_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  atp_pkg::ctrl_cmd_t                    cmd,
    output atp_pkg::dp_status_t                   status,
    input  logic                                  cfg_we,
    input  logic [atp_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [atp_pkg::GAIN_BITS-1:0]         cfg_data,
    input  logic signed [15:0]                    meas_sin,
    input  logic signed [15:0]                    meas_cos,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [15:0]                           est_angle,
    output logic signed [15:0]                    est_freq,
    output logic signed [15:0]                    phase_err
);

    // Loop state and gains.
    logic [atp_pkg::ANGLE_BITS-1:0] angle_reg, angle_next;
    logic signed [31:0]             integ_reg, integ_next;
    logic [atp_pkg::GAIN_BITS-1:0]  kp_reg, kp_next;
    logic [atp_pkg::GAIN_BITS-1:0]  ki_reg, ki_next;
    logic                           out_valid_reg, out_valid_next;

    // Working registers; lane 0 carries the sine, lane 1 the cosine.
    logic signed [15:0] ms_reg, ms_next;
    logic signed [15:0] mc_reg, mc_next;
    logic [16:0]        z_reg [2];
    logic [16:0]        z_next [2];
    logic [1:0]         quad_reg [2];
    logic [1:0]         quad_next [2];
    logic [16:0]        z2_reg [2];
    logic [16:0]        z2_next [2];
    logic [15:0]        t_reg [2];
    logic [15:0]        t_next [2];
    logic signed [15:0] sv_reg [2];
    logic signed [15:0] sv_next [2];
    logic signed [42:0] prod_reg [2];
    logic signed [42:0] prod_next [2];
    logic signed [42:0] pk_reg, pk_next;
    logic signed [15:0] err_reg, err_next;

    logic [15:0]        angle_out_reg, angle_out_next;
    logic signed [15:0] freq_out_reg, freq_out_next;
    logic signed [15:0] err_out_reg, err_out_next;

    // Multiplier operands and products.
    logic signed [24:0] op_a [2];
    logic signed [17:0] op_b [2];
    logic signed [42:0] mult [2];

    // Intermediate values.
    logic [15:0]        base_phase;
    logic [15:0]        lane_phase [2];
    logic [17:0]        mag;
    logic [15:0]        mag_sat;
    logic signed [33:0] diff;
    logic signed [18:0] err_sh;
    logic signed [32:0] integ_sum;
    logic signed [57:0] ctl;
    logic signed [41:0] freq_sh;
    logic signed [15:0] freq_val;
    logic signed [31:0] freq_ext;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            op_a[i] = '0;
            op_b[i] = '0;
            case (cmd.op)
                atp_pkg::OP_POLY1:
                begin
                    op_a[i] = signed'({8'h00, z_reg[i]});
                    op_b[i] = signed'({1'b0, z_reg[i]});
                end
                atp_pkg::OP_POLY2:
                begin
                    op_a[i] = signed'(atp_pkg::COEF_C);
                    op_b[i] = signed'({1'b0, z2_reg[i]});
                end
                atp_pkg::OP_POLY3:
                begin
                    op_a[i] = signed'({9'h000, t_reg[i]});
                    op_b[i] = signed'({1'b0, z2_reg[i]});
                end
                atp_pkg::OP_POLY4:
                begin
                    op_a[i] = signed'({9'h000, t_reg[i]});
                    op_b[i] = signed'({1'b0, z_reg[i]});
                end
                default:
                begin
                    op_a[i] = '0;
                    op_b[i] = '0;
                end
            endcase
            mult[i] = op_a[i] * op_b[i];
        end

        // Lane-specific operands of the error and gain products.
        case (cmd.op)
            atp_pkg::OP_MIX:
            begin
                op_a[0] = 25'(ms_reg);
                op_b[0] = 18'(sv_reg[1]);
                op_a[1] = 25'(mc_reg);
                op_b[1] = 18'(sv_reg[0]);
                mult[0] = op_a[0] * op_b[0];
                mult[1] = op_a[1] * op_b[1];
            end
            atp_pkg::OP_INTEG:
            begin
                op_a[0] = signed'({1'b0, kp_reg});
                op_b[0] = 18'(err_reg);
                mult[0] = op_a[0] * op_b[0];
            end
            atp_pkg::OP_GAIN:
            begin
                op_a[0] = signed'({1'b0, ki_reg});
                op_b[0] = signed'({2'b00, integ_reg[15:0]});
                op_a[1] = signed'({1'b0, ki_reg});
                op_b[1] = 18'(signed'(integ_reg[31:16]));
                mult[0] = op_a[0] * op_b[0];
                mult[1] = op_a[1] * op_b[1];
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        angle_next     = angle_reg;
        integ_next     = integ_reg;
        kp_next        = kp_reg;
        ki_next        = ki_reg;
        ms_next        = ms_reg;
        mc_next        = mc_reg;
        z_next         = z_reg;
        quad_next      = quad_reg;
        z2_next        = z2_reg;
        t_next         = t_reg;
        sv_next        = sv_reg;
        prod_next      = prod_reg;
        pk_next        = pk_reg;
        err_next       = err_reg;
        angle_out_next = angle_out_reg;
        freq_out_next  = freq_out_reg;
        err_out_next   = err_out_reg;
        out_valid_next = out_valid_reg && out_stall;

        mag       = '0;
        mag_sat   = '0;
        diff      = '0;
        err_sh    = '0;
        integ_sum = '0;
        ctl       = '0;
        freq_sh   = '0;
        freq_val  = '0;
        freq_ext  = '0;

        if (cfg_we)
        begin
            if (cfg_index == atp_pkg::REG_PROP_GAIN)
            begin
                kp_next = cfg_data;
            end
            else if (cfg_index == atp_pkg::REG_INTEG_GAIN)
            begin
                ki_next = cfg_data;
            end
        end

        // Fold the table phase of sine and cosine into the first quadrant.
        base_phase    = atp_pkg::turn_phase(angle_reg) & atp_pkg::PHASE_MASK;
        lane_phase[0] = base_phase;
        lane_phase[1] = base_phase + atp_pkg::QUARTER_TURN;
        if (cmd.load)
        begin
            ms_next = meas_sin;
            mc_next = meas_cos;
            for (int i = 0; i < 2; i++)
            begin
                quad_next[i] = lane_phase[i][15:14];
                if (lane_phase[i][14])
                begin
                    z_next[i] = atp_pkg::Z_FULL - {2'b00, lane_phase[i][13:0], 1'b0};
                end
                else
                begin
                    z_next[i] = {2'b00, lane_phase[i][13:0], 1'b0};
                end
            end
        end

        case (cmd.op)
            atp_pkg::OP_POLY1:
            begin
                for (int i = 0; i < 2; i++)
                begin
                    z2_next[i] = mult[i][31:15];
                end
            end
            atp_pkg::OP_POLY2:
            begin
                for (int i = 0; i < 2; i++)
                begin
                    t_next[i] = atp_pkg::COEF_B - mult[i][30:15];
                end
            end
            atp_pkg::OP_POLY3:
            begin
                for (int i = 0; i < 2; i++)
                begin
                    t_next[i] = atp_pkg::COEF_A - mult[i][30:15];
                end
            end
            atp_pkg::OP_POLY4:
            begin
                for (int i = 0; i < 2; i++)
                begin
                    mag = mult[i][32:15];
                    if (mag > 18'd32767)
                    begin
                        mag_sat = 16'h7FFF;
                    end
                    else
                    begin
                        mag_sat = mag[15:0];
                    end
                    if (quad_reg[i][1])
                    begin
                        sv_next[i] = -signed'(mag_sat);
                    end
                    else
                    begin
                        sv_next[i] = signed'(mag_sat);
                    end
                end
            end
            atp_pkg::OP_MIX:
            begin
                prod_next[0] = mult[0];
                prod_next[1] = mult[1];
            end
            atp_pkg::OP_ERR:
            begin
                diff   = 34'(prod_reg[0]) - 34'(prod_reg[1]);
                err_sh = 19'(diff >>> 15);
                if (err_sh > 19'sd32767)
                begin
                    err_next = 16'sh7FFF;
                end
                else if (err_sh < -19'sd32768)
                begin
                    err_next = -16'sd32768;
                end
                else
                begin
                    err_next = err_sh[15:0];
                end
            end
            atp_pkg::OP_INTEG:
            begin
                integ_sum = 33'(integ_reg) + 33'(err_reg);
                if (integ_sum > 33'sd2147483647)
                begin
                    integ_next = 32'sh7FFF_FFFF;
                end
                else if (integ_sum < -33'sd2147483648)
                begin
                    integ_next = 32'sh8000_0000;
                end
                else
                begin
                    integ_next = integ_sum[31:0];
                end
                prod_next[0] = mult[0];
            end
            atp_pkg::OP_GAIN:
            begin
                pk_next      = prod_reg[0];
                prod_next[0] = mult[0];
                prod_next[1] = mult[1];
            end
            atp_pkg::OP_FREQ:
            begin
                // The integral product is split at bit 16 into an upper and lower half.
                ctl = 58'(pk_reg) + (58'(prod_reg[1]) <<< 16) + 58'(prod_reg[0]);
                freq_sh = 42'(ctl >>> 16);
                if (freq_sh > 42'sd32767)
                begin
                    freq_val = 16'sh7FFF;
                end
                else if (freq_sh < -42'sd32768)
                begin
                    freq_val = -16'sd32768;
                end
                else
                begin
                    freq_val = freq_sh[15:0];
                end
                freq_ext       = 32'(freq_val);
                angle_next     = angle_reg + freq_ext[atp_pkg::ANGLE_BITS-1:0];
                angle_out_next = atp_pkg::turn_phase(angle_next);
                freq_out_next  = freq_val;
                err_out_next   = err_reg;
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg     <= '0;
            integ_reg     <= '0;
            kp_reg        <= atp_pkg::PROP_GAIN_RESET;
            ki_reg        <= atp_pkg::INTEG_GAIN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            angle_reg     <= angle_next;
            integ_reg     <= integ_next;
            kp_reg        <= kp_next;
            ki_reg        <= ki_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ms_reg        <= ms_next;
        mc_reg        <= mc_next;
        z_reg         <= z_next;
        quad_reg      <= quad_next;
        z2_reg        <= z2_next;
        t_reg         <= t_next;
        sv_reg        <= sv_next;
        prod_reg      <= prod_next;
        pk_reg        <= pk_next;
        err_reg       <= err_next;
        angle_out_reg <= angle_out_next;
        freq_out_reg  <= freq_out_next;
        err_out_reg   <= err_out_next;
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign est_angle       = angle_out_reg;
    assign est_freq        = freq_out_reg;
    assign phase_err       = err_out_reg;

endmodule

// File: design/angle_tracking_pll_unit.sv
// ----------------------------------------------------------------------------
// angle_tracking_pll_unit
// Resolver angle tracking loop: sin/cos sample in, angle, frequency and error out.
// ----------------------------------------------------------------------------
// Each accepted sin/cos pair runs a full update before the next input
// transfer is taken; the result is registered in the final step. The two
// shared multiplier lanes evaluate the sine and cosine polynomials in four
// steps and then the error and gain products in three more. A new sample
// is taken while the previous result still waits in the output register; a
// result still held when the next update reaches its final step holds that
// step. Gains are written through cfg_we/cfg_index/cfg_data while the block
// is idle; the user must keep to this, as the block does not enforce it.
module angle_tracking_pll_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [atp_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [atp_pkg::GAIN_BITS-1:0]         cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [15:0]                    meas_sin,
    input  logic signed [15:0]                    meas_cos,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [15:0]                           est_angle,
    output logic signed [15:0]                    est_freq,
    output logic signed [15:0]                    phase_err
);

    atp_pkg::ctrl_cmd_t  cmd;
    atp_pkg::dp_status_t status;

    atp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    atp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .meas_sin  (meas_sin),
        .meas_cos  (meas_cos),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .est_angle (est_angle),
        .est_freq  (est_freq),
        .phase_err (phase_err)
    );

endmodule

// File: design/atp_checker.sv
// ----------------------------------------------------------------------------
// atp_checker
// Port-level checks of the angle tracking loop, bound to the top level.
// ----------------------------------------------------------------------------
module atp_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [15:0]        est_angle,
    input  logic signed [15:0] est_freq,
    input  logic signed [15:0] phase_err
);

    // A stalled result stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(est_angle)
            && $stable(est_freq) && $stable(phase_err))
        else $error("result changed while stalled");

    // An input transfer starts an update, so the input side is busy next.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not held off after transfer");

    // The block only becomes busy because of an input transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid))
        else $error("busy without an input transfer");

    // A fresh result appears only at the end of an update.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without an update in progress");

endmodule

bind angle_tracking_pll_unit atp_checker u_atp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .est_angle (est_angle),
    .est_freq  (est_freq),
    .phase_err (phase_err)
);
